@@ rtl/emx_pkg.sv @@
// ----------------------------------------------------------------------------
// emx_pkg
// Shared types and codes for the modular exponentiation engine.
// ----------------------------------------------------------------------------
package emx_pkg;

	localparam int unsigned FieldW = 32;

	typedef enum logic [1:0] {
		MODE_KEYGEN  = 2'd0,
		MODE_ENCRYPT = 2'd1,
		MODE_DECRYPT = 2'd2,
		MODE_NONE    = 2'd3
	} mode_t;

	typedef enum logic [1:0] {
		REG_PRIME = 2'd0,
		REG_GEN   = 2'd1,
		REG_PRIV  = 2'd2,
		REG_PUB   = 2'd3
	} reg_idx_t;

	typedef struct packed {
		logic [1:0]        mode;
		logic [FieldW-1:0] random_word;
		logic [FieldW-1:0] message;
		logic [FieldW-1:0] cipher_first;
		logic [FieldW-1:0] cipher_second;
	} in_item_t;

	typedef struct packed {
		logic [FieldW-1:0] first_result;
		logic [FieldW-1:0] second_result;
	} out_item_t;

	// Operation codes for the shared modular unit
	typedef enum logic [1:0] {
		OP_MUL = 2'd0,
		OP_RED = 2'd1
	} mop_t;

	// Request and status between sequencer and arithmetic unit
	typedef struct packed {
		logic start;
		mop_t op;
	} mu_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} mu_sts_t;

endpackage

@@ rtl/emx_modunit.sv @@
// ----------------------------------------------------------------------------
// emx_modunit
// Shared modular unit: bit-serial double-and-add multiply x*y mod m, or
// restoring reduction y mod m. One bit per cycle.
// ----------------------------------------------------------------------------
module emx_modunit #(
	parameter int unsigned W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  emx_pkg::mu_ctl_t        ctl,
	input  logic [W-1:0]            x,
	input  logic [W-1:0]            y,
	input  logic [W-1:0]            m,
	output emx_pkg::mu_sts_t        sts,
	output logic [W-1:0]            res
);

	localparam int unsigned CW = $clog2(W + 1);

	logic          busy_q;
	logic          done_q;
	logic [CW-1:0] cnt_q;
	logic [W-1:0]  r_q;
	logic [W-1:0]  x_q;
	logic [W-1:0]  y_q;
	logic [W-1:0]  m_q;
	logic          red_q;

	logic [W:0]    dbl;
	logic [W:0]    dbl_red;
	logic [W:0]    add;
	logic [W-1:0]  nxt;

	// One step: r = 2r (+ shifted-in bit) mod m, then + x mod m for multiply when the top y bit is set
	always_comb begin
		dbl = {r_q, (red_q ? y_q[W-1] : 1'b0)};
		dbl_red = (dbl >= {1'b0, m_q}) ? dbl - {1'b0, m_q} : dbl;
		add = dbl_red + {1'b0, x_q};
		if (!red_q && y_q[W-1]) begin
			nxt = (add >= {1'b0, m_q}) ? W'(add - {1'b0, m_q}) : add[W-1:0];
		end else begin
			nxt = dbl_red[W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start && !busy_q) begin
			r_q   <= '0;
			x_q   <= x;
			y_q   <= y;
			m_q   <= m;
			red_q <= (ctl.op == emx_pkg::OP_RED);
		end else if (busy_q) begin
			r_q <= nxt;
			y_q <= {y_q[W-2:0], 1'b0};
		end
	end

	assign sts.busy = busy_q;
	assign sts.done = done_q;
	assign res      = r_q;

endmodule

@@ rtl/emx_seq.sv @@
// ----------------------------------------------------------------------------
// emx_seq
// Sequencer: reduces operands, runs square-and-multiply exponentiations on
// the shared modular unit and assembles the two result words.
// ----------------------------------------------------------------------------
module emx_seq #(
	parameter int unsigned W = 32
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	input  emx_pkg::in_item_t       item,
	input  logic [W-1:0]            p,
	input  logic [W-1:0]            g,
	input  logic [W-1:0]            a,
	input  logic [W-1:0]            h,
	output logic                    busy,
	output logic                    done,
	output emx_pkg::out_item_t      result
);

	typedef enum logic [11:0] {
		S_IDLE   = 12'b000000000001,
		S_RW     = 12'b000000000010,
		S_RM     = 12'b000000000100,
		S_RC1    = 12'b000000001000,
		S_RC2    = 12'b000000010000,
		S_RG     = 12'b000000100000,
		S_PSET   = 12'b000001000000,
		S_PMUL   = 12'b000010000000,
		S_PSQR   = 12'b000100000000,
		S_NEXT   = 12'b001000000000,
		S_FMUL   = 12'b010000000000,
		S_DONE   = 12'b100000000000
	} st_t;

	// Phases of one item
	typedef enum logic [2:0] {
		PH_G    = 3'd0,
		PH_H    = 3'd1,
		PH_S    = 3'd2,
		PH_INV  = 3'd3,
		PH_LAST = 3'd4
	} ph_t;

	st_t               st_q;
	ph_t               ph_q;
	logic [1:0]        mode_q;
	logic [W-1:0]      p_q;
	logic [W-1:0]      w_q;
	logic [W-1:0]      m_q;
	logic [W-1:0]      c1_q;
	logic [W-1:0]      c2_q;
	logic [W-1:0]      g_q;
	logic [W-1:0]      h_q;
	logic [W-1:0]      a_q;
	logic [W-1:0]      k_q;
	logic [W-1:0]      e_q;
	logic [W-1:0]      b_q;
	logic [W-1:0]      r_q;
	logic [W-1:0]      r0_q;
	logic [W-1:0]      r1_q;
	logic              issued_q;

	emx_pkg::mu_ctl_t  mctl;
	emx_pkg::mu_sts_t  msts;
	logic [W-1:0]      mx;
	logic [W-1:0]      my;
	logic [W-1:0]      mm;
	logic [W-1:0]      mres;
	logic [W-1:0]      p_m2;

	assign p_m2 = p_q - W'(2);

	emx_modunit #(.W(W)) u_mu (
		.clk    (clk),
		.arst_n (arst_n),
		.ctl    (mctl),
		.x      (mx),
		.y      (my),
		.m      (mm),
		.sts    (msts),
		.res    (mres)
	);

	// Operand selection per state; reduction uses x=0, y=value
	always_comb begin
		mctl.start = 1'b0;
		mctl.op    = emx_pkg::OP_MUL;
		mx         = '0;
		my         = '0;
		mm         = p_q;
		case (st_q)
			S_RW: begin
				mctl.op = emx_pkg::OP_RED; my = w_q; mm = p_m2;
			end
			S_RM: begin
				mctl.op = emx_pkg::OP_RED; my = m_q;
			end
			S_RC1: begin
				mctl.op = emx_pkg::OP_RED; my = c1_q;
			end
			S_RC2: begin
				mctl.op = emx_pkg::OP_RED; my = c2_q;
			end
			S_RG: begin
				mctl.op = emx_pkg::OP_RED; my = (ph_q == PH_H) ? h_q : g_q;
			end
			S_PMUL: begin
				mx = r_q; my = b_q;
			end
			S_PSQR: begin
				mx = b_q; my = b_q;
			end
			S_FMUL: begin
				mx = r1_q; my = r_q;
			end
			default: ;
		endcase
		mctl.start = !issued_q && (st_q == S_RW || st_q == S_RM || st_q == S_RC1 ||
			st_q == S_RC2 || st_q == S_RG || st_q == S_PMUL || st_q == S_PSQR ||
			st_q == S_FMUL);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q     <= S_IDLE;
			issued_q <= 1'b0;
		end else begin
			if (mctl.start) issued_q <= 1'b1;
			if (msts.done) issued_q <= 1'b0;
			case (st_q)
				S_IDLE: if (start) begin
					if (p < W'(3) || item.mode == emx_pkg::MODE_NONE) st_q <= S_DONE;
					else if (item.mode == emx_pkg::MODE_DECRYPT) st_q <= S_RC1;
					else st_q <= S_RW;
				end
				S_RW:   if (msts.done) st_q <= (mode_q == emx_pkg::MODE_ENCRYPT) ? S_RM : S_RG;
				S_RM:   if (msts.done) st_q <= S_RG;
				S_RC1:  if (msts.done) st_q <= S_RC2;
				S_RC2:  if (msts.done) st_q <= S_PSET;
				S_RG:   if (msts.done) st_q <= S_PSET;
				S_PSET: st_q <= (e_q == '0) ? S_NEXT : (e_q[0] ? S_PMUL : S_PSQR);
				S_PMUL: if (msts.done) st_q <= S_PSQR;
				// Decide on the exponent after this square shifts it
				S_PSQR: if (msts.done)
					st_q <= ((e_q >> 1) == '0) ? S_NEXT : (e_q[1] ? S_PMUL : S_PSQR);
				S_NEXT: begin
					case (ph_q)
						PH_G:   st_q <= (mode_q == emx_pkg::MODE_ENCRYPT) ? S_RG : S_DONE;
						PH_H:   st_q <= S_FMUL;
						PH_S:   st_q <= S_PSET;
						PH_INV: st_q <= S_FMUL;
						default: st_q <= S_DONE;
					endcase
				end
				S_FMUL: if (msts.done) st_q <= S_DONE;
				S_DONE: st_q <= S_IDLE;
				default: st_q <= S_IDLE;
			endcase
		end
	end

	// Datapath registers
	always_ff @(posedge clk) begin
		case (st_q)
			S_IDLE: if (start) begin
				mode_q <= item.mode;
				p_q    <= p;
				g_q    <= g;
				h_q    <= h;
				a_q    <= a;
				w_q    <= W'(item.random_word);
				m_q    <= W'(item.message);
				c1_q   <= W'(item.cipher_first);
				c2_q   <= W'(item.cipher_second);
				ph_q   <= (item.mode == emx_pkg::MODE_DECRYPT) ? PH_S : PH_G;
				r0_q   <= '0;
				r1_q   <= '0;
			end
			S_RW:  if (msts.done) begin k_q <= mres + W'(1); r0_q <= mres + W'(1); end
			S_RM:  if (msts.done) r1_q <= mres;
			S_RC1: if (msts.done) b_q <= mres;
			S_RC2: if (msts.done) begin r1_q <= mres; e_q <= a_q; end
			S_RG:  if (msts.done) begin b_q <= mres; e_q <= k_q; end
			S_PSET: r_q <= W'(1);
			S_PMUL: if (msts.done) r_q <= mres;
			S_PSQR: if (msts.done) begin b_q <= mres; e_q <= e_q >> 1; end
			S_NEXT: begin
				case (ph_q)
					PH_G: begin
						if (mode_q == emx_pkg::MODE_ENCRYPT) begin
							r0_q <= r_q; ph_q <= PH_H;
						end else r1_q <= r_q;
					end
					PH_H: ph_q <= PH_LAST;
					PH_S: begin
						b_q <= r_q; e_q <= p_m2; ph_q <= PH_INV;
					end
					default: ph_q <= PH_LAST;
				endcase
			end
			S_FMUL: if (msts.done) begin
				if (mode_q == emx_pkg::MODE_ENCRYPT) r1_q <= mres;
				else begin r0_q <= mres; r1_q <= '0; end
			end
			default: ;
		endcase
	end

	assign busy = (st_q != S_IDLE);
	assign done = (st_q == S_DONE);
	assign result.first_result  = emx_pkg::FieldW'(r0_q);
	assign result.second_result = emx_pkg::FieldW'(r1_q);

endmodule

@@ rtl/elgamal_modexp_engine_top.sv @@
// ----------------------------------------------------------------------------
// elgamal_modexp_engine_top
// ElGamal key generation, encryption and decryption over a prime modulus.
// ----------------------------------------------------------------------------
// One transaction at a time: in_ready is low from acceptance until the result
// has been taken on the output side. All arithmetic runs on one bit-serial
// modular unit of width max(MOD_BITS, 32), so that full 32-bit input words
// reduce correctly. An exponentiation costs one square per exponent bit plus
// one multiply per set bit. Key generation runs one exponentiation; encrypt
// and decrypt run two. Mode 3 and a modulus below 3 skip all arithmetic and
// go straight to the done state.
module elgamal_modexp_engine_top #(
	parameter int unsigned MOD_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  emx_pkg::in_item_t    in_data,
	output logic                 out_valid,
	input  logic                 out_ready,
	output emx_pkg::out_item_t   out_data,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [1:0]           cfg_index,
	input  logic [31:0]          cfg_data
);

	// Datapath width: wide enough for the modulus and for full input words
	localparam int unsigned SeqW = (MOD_BITS > emx_pkg::FieldW) ? MOD_BITS :
		emx_pkg::FieldW;

	logic [31:0]         p_q, g_q, a_q, h_q;
	logic                busy, done;
	emx_pkg::out_item_t  res;
	emx_pkg::out_item_t  out_q;
	logic                ov_q;
	logic                start;

	assign cfg_ready = 1'b1;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q <= 32'd3; g_q <= 32'd2; a_q <= 32'd1; h_q <= 32'd1;
		end else if (cfg_valid) begin
			case (emx_pkg::reg_idx_t'(cfg_index))
				emx_pkg::REG_PRIME: p_q <= cfg_data;
				emx_pkg::REG_GEN:   g_q <= cfg_data;
				emx_pkg::REG_PRIV:  a_q <= cfg_data;
				emx_pkg::REG_PUB:   h_q <= cfg_data;
				default: ;
			endcase
		end
	end

	assign in_ready = !busy && !ov_q;
	assign start    = in_valid && in_ready;

	// Registers are masked to MOD_BITS, then widened to the datapath
	emx_seq #(.W(SeqW)) u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (in_data),
		.p      (SeqW'(MOD_BITS'(p_q))),
		.g      (SeqW'(MOD_BITS'(g_q))),
		.a      (SeqW'(MOD_BITS'(a_q))),
		.h      (SeqW'(MOD_BITS'(h_q))),
		.busy   (busy),
		.done   (done),
		.result (res)
	);

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) ov_q <= 1'b0;
		else if (done) ov_q <= 1'b1;
		else if (out_ready) ov_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) out_q <= res;
	end

	assign out_valid = ov_q;
	assign out_data  = out_q;

	a_no_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start |=> !in_ready) else $error("accepted while busy");
	a_done_free: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !ov_q) else $error("result overwrite");
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(ov_q && !out_ready) |=> $stable(out_q)) else $error("result changed");

endmodule
